/* rtl/core/frsb_pkg.sv */
// frame ring buffer package: sizes, codes, command struct and pointer helpers
// used by every file of the frame ring buffer; depends on nothing
package frsb_pkg;

    // ring geometry
    localparam int MAX_FRAMES   = 16;
    localparam int MAX_SENSORS  = 8;
    localparam int MAX_CHANNELS = 8;
    localparam int FRAME_W      = $clog2(MAX_FRAMES);
    localparam int SENS_W       = $clog2(MAX_SENSORS);
    localparam int CHAN_W       = $clog2(MAX_CHANNELS);
    localparam int ADDR_W       = FRAME_W + SENS_W + CHAN_W;
    localparam int STORE_DEPTH  = MAX_FRAMES * MAX_SENSORS * MAX_CHANNELS;

    // field widths
    localparam int OP_W     = 3;
    localparam int FIDX_W   = 4;
    localparam int SIDX_W   = 3;
    localparam int CIDX_W   = 3;
    localparam int WORD_W   = 32;
    localparam int STAT_W   = 2;
    localparam int CNT_W    = 4;
    localparam int PTR_W    = 4;

    // configuration port
    localparam int CFG_AW     = 2;
    localparam int CFG_DW     = 5;
    localparam int CFG_FW     = 5;
    localparam int CFG_SW     = 4;
    localparam int CFG_CW     = 4;
    localparam logic [CFG_AW-1:0] CFG_FRAMES   = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_SENSORS  = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_CHANNELS = 2'd2;
    localparam logic [CFG_FW-1:0] RST_FRAMES   = 5'd16;
    localparam logic [CFG_SW-1:0] RST_SENSORS  = 4'd8;
    localparam logic [CFG_CW-1:0] RST_CHANNELS = 4'd8;

    // operations
    localparam logic [OP_W-1:0] OP_WRITE   = 3'd0;
    localparam logic [OP_W-1:0] OP_COMMIT  = 3'd1;
    localparam logic [OP_W-1:0] OP_READ    = 3'd2;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_AT = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

    // command handed from the front part to the memory side
    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] wdata;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  frames;
        logic [PTR_W-1:0]  wp;
        logic [PTR_W-1:0]  rp;
    } t_cmd;

    // step a frame pointer, wrapping at the slot count
    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                 input logic [CFG_FW-1:0] slots);
        logic [CFG_FW-1:0] n;
        n = {1'b0, p} + CFG_FW'(1);
        return (n >= slots) ? '0 : n[PTR_W-1:0];
    endfunction

endpackage

/* rtl/core/frsb_if.sv */
// request and result channel interfaces of the frame ring buffer
// depends on frsb_pkg for field widths
interface frsb_req_if;
    import frsb_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [FIDX_W-1:0] frame_index;
    logic [SIDX_W-1:0] sensor_index;
    logic [CIDX_W-1:0] channel_index;
    logic [WORD_W-1:0] write_word;
    modport source (output valid, operation, frame_index, sensor_index, channel_index,
                    write_word, input ready);
    modport sink (input valid, operation, frame_index, sensor_index, channel_index,
                  write_word, output ready);
endinterface

interface frsb_rsp_if;
    import frsb_pkg::*;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [WORD_W-1:0] read_word;
    logic [CNT_W-1:0]  frames_available;
    logic [PTR_W-1:0]  write_frame;
    logic [PTR_W-1:0]  read_frame;
    modport source (output valid, status, read_word, frames_available, write_frame,
                    read_frame, input ready);
    modport sink (input valid, status, read_word, frames_available, write_frame,
                  read_frame, output ready);
endinterface

/* rtl/core/frsb_front.sv */
// front part: config registers, request classification, frame pointers and count
// depends on frsb_pkg; feeds commands to the queue
module frsb_front
    import frsb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wdata,
    input  logic              i_busy,
    input  logic              i_q_full,
    frsb_req_if.sink          i_req,
    output logic              o_push,
    output t_cmd              o_cmd
);

    logic [CFG_FW-1:0] r_cfg_frames;
    logic [CFG_SW-1:0] r_cfg_sensors;
    logic [CFG_CW-1:0] r_cfg_channels;
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic [PTR_W-1:0]  r_rp, n_rp;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CFG_FW-1:0] eff_frames;
    logic [CFG_SW-1:0] eff_sensors;
    logic [CFG_CW-1:0] eff_channels;
    logic              sc_ok;
    logic [STAT_W-1:0] status;
    logic              we;
    logic              re;
    logic [PTR_W-1:0]  frame_sel;

    // configuration writes, unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_frames   <= RST_FRAMES;
            r_cfg_sensors  <= RST_SENSORS;
            r_cfg_channels <= RST_CHANNELS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_FRAMES:   r_cfg_frames   <= i_cfg_wdata[CFG_FW-1:0];
                CFG_SENSORS:  r_cfg_sensors  <= i_cfg_wdata[CFG_SW-1:0];
                CFG_CHANNELS: r_cfg_channels <= i_cfg_wdata[CFG_CW-1:0];
                default: ;
            endcase
        end
    end

    // saturate the limits into their legal ranges
    always_comb begin
        if (r_cfg_frames < CFG_FW'(2))               eff_frames = CFG_FW'(2);
        else if (r_cfg_frames > CFG_FW'(MAX_FRAMES)) eff_frames = CFG_FW'(MAX_FRAMES);
        else                                         eff_frames = r_cfg_frames;
        if (r_cfg_sensors < CFG_SW'(1))                eff_sensors = CFG_SW'(1);
        else if (r_cfg_sensors > CFG_SW'(MAX_SENSORS)) eff_sensors = CFG_SW'(MAX_SENSORS);
        else                                           eff_sensors = r_cfg_sensors;
        if (r_cfg_channels < CFG_CW'(1))                 eff_channels = CFG_CW'(1);
        else if (r_cfg_channels > CFG_CW'(MAX_CHANNELS)) eff_channels = CFG_CW'(MAX_CHANNELS);
        else                                             eff_channels = r_cfg_channels;
    end

    assign sc_ok = ({1'b0, i_req.sensor_index} < eff_sensors)
                && ({1'b0, i_req.channel_index} < eff_channels);

    // classify the request and work out the pointer updates
    always_comb begin
        status    = ST_OK;
        we        = 1'b0;
        re        = 1'b0;
        frame_sel = r_wp;
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_cnt     = r_cnt;
        unique case (i_req.operation)
            OP_WRITE: begin
                if (!sc_ok) status = ST_RANGE;
                else        we = 1'b1;
            end
            OP_COMMIT: begin
                if (({1'b0, r_cnt} + CFG_FW'(1)) >= eff_frames) begin
                    status = ST_FULL;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                    n_wp  = advance(r_wp, eff_frames);
                end
            end
            OP_READ: begin
                frame_sel = r_rp;
                if (r_cnt == '0) status = ST_EMPTY;
                else if (!sc_ok) status = ST_RANGE;
                else             re = 1'b1;
            end
            OP_RELEASE: begin
                if (r_cnt == '0) begin
                    status = ST_EMPTY;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                    n_rp  = advance(r_rp, eff_frames);
                end
            end
            OP_READ_AT: begin
                frame_sel = i_req.frame_index;
                if (({1'b0, i_req.frame_index} >= eff_frames) || !sc_ok) status = ST_RANGE;
                else                                                     re = 1'b1;
            end
            default: status = ST_RANGE;
        endcase
    end

    assign i_req.ready = !i_busy && !i_q_full;
    assign o_push      = i_req.valid && i_req.ready;

    // command for the memory side, results taken after the access
    always_comb begin
        o_cmd.we     = we;
        o_cmd.re     = re;
        o_cmd.addr   = {frame_sel, i_req.sensor_index, i_req.channel_index};
        o_cmd.wdata  = i_req.write_word;
        o_cmd.status = status;
        o_cmd.frames = n_cnt;
        o_cmd.wp     = n_wp;
        o_cmd.rp     = n_rp;
    end

    // pointer and count state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else if (o_push) begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

/* rtl/core/frsb_queue.sv */
// two-entry command queue between the front part and the memory side
// depends on frsb_pkg for the command struct
module frsb_queue
    import frsb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_head
);

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_slot[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wr_ptr] <= i_cmd;
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_pop)  r_rd_ptr <= ~r_rd_ptr;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* rtl/core/frsb_back.sv */
// memory side: sample store with clearing pass, read stage and result register
// depends on frsb_pkg; drains the command queue
module frsb_back
    import frsb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_cmd       i_head,
    output logic       o_pop,
    output logic       o_busy,
    frsb_rsp_if.source o_rsp
);

    logic [WORD_W-1:0] r_store [STORE_DEPTH];
    logic              r_clr_active;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [WORD_W-1:0] r_rd_data;
    logic              r_s1_v;
    logic              r_s1_re;
    logic [STAT_W-1:0] r_s1_status;
    logic [CNT_W-1:0]  r_s1_frames;
    logic [PTR_W-1:0]  r_s1_wp;
    logic [PTR_W-1:0]  r_s1_rp;
    logic              r_o_v;
    logic [STAT_W-1:0] r_o_status;
    logic [WORD_W-1:0] r_o_word;
    logic [CNT_W-1:0]  r_o_frames;
    logic [PTR_W-1:0]  r_o_wp;
    logic [PTR_W-1:0]  r_o_rp;
    logic              o_load;

    assign o_busy = r_clr_active;
    assign o_load = r_s1_v && (!r_o_v || o_rsp.ready);
    assign o_pop  = !r_clr_active && !i_q_empty && (!r_s1_v || o_load);

    // clearing pass over the whole store after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == ADDR_W'(STORE_DEPTH - 1)) r_clr_active <= 1'b0;
        end
    end

    // sample store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (r_clr_active)             r_store[r_clr_addr]  <= '0;
        else if (o_pop && i_head.we)  r_store[i_head.addr] <= i_head.wdata;
        if (o_pop && i_head.re)       r_rd_data <= r_store[i_head.addr];
    end

    // read stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)    r_s1_v <= 1'b0;
        else if (o_pop)  r_s1_v <= 1'b1;
        else if (o_load) r_s1_v <= 1'b0;
    end

    // read stage payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_re     <= i_head.re;
            r_s1_status <= i_head.status;
            r_s1_frames <= i_head.frames;
            r_s1_wp     <= i_head.wp;
            r_s1_rp     <= i_head.rp;
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)          r_o_v <= 1'b0;
        else if (o_load)       r_o_v <= 1'b1;
        else if (o_rsp.ready)  r_o_v <= 1'b0;
    end

    // result register payload, read word zero unless a read succeeded
    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_o_status <= r_s1_status;
            r_o_word   <= r_s1_re ? r_rd_data : '0;
            r_o_frames <= r_s1_frames;
            r_o_wp     <= r_s1_wp;
            r_o_rp     <= r_s1_rp;
        end
    end

    assign o_rsp.valid            = r_o_v;
    assign o_rsp.status           = r_o_status;
    assign o_rsp.read_word        = r_o_word;
    assign o_rsp.frames_available = r_o_frames;
    assign o_rsp.write_frame      = r_o_wp;
    assign o_rsp.read_frame       = r_o_rp;

endmodule

/* rtl/core/sensor_frame_ring_buffer.sv */
// Frame ring buffer for sensor samples, one 32-bit word per sensor and channel.
// Request channel i_req carries an operation (write word, commit frame, read
// oldest, release oldest, read indexed frame) with indices and a write word;
// each accepted request gives exactly one result on o_rsp with status, read
// word, frames available and both frame pointers as they stand after it.
// Configuration: i_cfg_we writes i_cfg_wdata to the register i_cfg_addr
// (0 frames in use, 1 sensors in use, 2 channels in use); write only while idle.
// A request passes the command queue, the read stage and the result register.
// Throughput: one request per cycle while results are taken; the store has one
// write and one read port, and each request takes at most one access through
// the two-entry command queue. Reset: pointers and count clear, registers
// return to 16/8/8, and a clearing pass writes zero to all 1024 store words,
// one per cycle; i_req.ready stays low until the pass is done.
// Receiver stall: the result register holds; the read stage and the queue
// fill behind it, then i_req.ready drops until the result is taken.
// depends on frsb_pkg, frsb_if, frsb_front, frsb_queue, frsb_back
module sensor_frame_ring_buffer
    import frsb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wdata,
    frsb_req_if.sink          i_req,
    frsb_rsp_if.source        o_rsp
);

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    logic busy;
    t_cmd cmd;
    t_cmd head;

    // request classification and pointer state
    frsb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_busy      (busy),
        .i_q_full    (q_full),
        .i_req       (i_req),
        .o_push      (push),
        .o_cmd       (cmd)
    );

    // decoupling queue
    frsb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    // store access and result
    frsb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_head    (head),
        .o_pop     (pop),
        .o_busy    (busy),
        .o_rsp     (o_rsp)
    );

endmodule

/* rtl/core/frsb_checker.sv */
// port-level checks on the result channel of the frame ring buffer
// depends on frsb_pkg; bound to sensor_frame_ring_buffer
module frsb_checker
    import frsb_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              i_ready,
    input logic [STAT_W-1:0] i_status,
    input logic [WORD_W-1:0] i_read_word,
    input logic [CNT_W-1:0]  i_frames
);

    // a failed access never returns data
    a_word_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status != ST_OK) |-> (i_read_word == '0))
        else $error("read word nonzero on failed request");

    // the ring always keeps one slot free
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_frames <= CNT_W'(MAX_FRAMES - 1)))
        else $error("frames available beyond ring capacity");

    // empty status only with no frames held, full only with some
    a_empty_means_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status == ST_EMPTY) |-> (i_frames == '0))
        else $error("empty status with frames available");

    a_full_means_some: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status == ST_FULL) |-> (i_frames != '0))
        else $error("full status with no frames held");

    // a stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_status) && $stable(i_read_word)
                                && $stable(i_frames))
        else $error("stalled result changed");

endmodule

bind sensor_frame_ring_buffer frsb_checker u_frsb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_rsp.valid),
    .i_ready     (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_read_word (o_rsp.read_word),
    .i_frames    (o_rsp.frames_available)
);
